// ===== src/svft_pkg.sv =====
package svft_pkg;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 25;
    localparam int TOL_W   = 16;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 6;
    localparam int USED_W  = 7;
    localparam int CFG_W   = 32;
    localparam int CFGI_W  = 2;

    // Exact difference of two Q16.16 values needs one extra bit; two are kept
    localparam int DIFF_W  = VALUE_W + 2;

    localparam int TABLE_DEPTH_DEF = 64;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] REG_NODATA      = 2'd0;
    localparam logic [CFGI_W-1:0] REG_TOLERANCE   = 2'd1;
    localparam logic [CFGI_W-1:0] REG_PIXEL_TOTAL = 2'd2;

    // Register reset values
    localparam logic signed [VALUE_W-1:0] NODATA_RST = '0;
    localparam logic [TOL_W-1:0]          TOL_RST    = 16'd7;
    localparam logic [COUNT_W-1:0]        TOTAL_RST  = 25'd65536;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_COUNTED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_SKIPPED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_INDEX = 3'd4,
        ST_DONE      = 3'd5
    } status_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic count_en;
        logic insert_en;
    } cell_ctrl_t;

    // Per-cell compare result handed along the chain
    typedef struct packed {
        logic hit;         // entry is free, near the sample, or above it
        logic near_first;  // first hit of the chain and within tolerance
    } cell_stat_t;

    // a - b, exact
    function automatic logic signed [DIFF_W-1:0] value_diff(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic signed [DIFF_W-1:0] ax;
        logic signed [DIFF_W-1:0] bx;
        ax = DIFF_W'(a);
        bx = DIFF_W'(b);
        return ax - bx;
    endfunction

    // diff > -tol
    function automatic logic above_low(
        input logic signed [DIFF_W-1:0] diff,
        input logic [TOL_W-1:0]         tol
    );
        logic signed [DIFF_W-1:0] sum;
        sum = diff + $signed({{(DIFF_W-TOL_W){1'b0}}, tol});
        return !sum[DIFF_W-1] && (sum != '0);
    endfunction

    // diff < tol
    function automatic logic below_high(
        input logic signed [DIFF_W-1:0] diff,
        input logic [TOL_W-1:0]         tol
    );
        return diff < $signed({{(DIFF_W-TOL_W){1'b0}}, tol});
    endfunction

endpackage

// ===== src/svft_cell.sv =====
module svft_cell (
    input  logic                                  clk,
    input  svft_pkg::cell_ctrl_t                  ctrl,
    input  logic                                  valid,
    input  logic signed [svft_pkg::VALUE_W-1:0]   sample,
    input  logic [svft_pkg::TOL_W-1:0]            tolerance,
    input  logic [svft_pkg::COUNT_W-1:0]          limit,
    input  logic                                  prev_hit,
    input  logic signed [svft_pkg::VALUE_W-1:0]   prev_value,
    input  logic [svft_pkg::COUNT_W-1:0]          prev_count,
    output svft_pkg::cell_stat_t                  stat,
    output logic signed [svft_pkg::VALUE_W-1:0]   value,
    output logic [svft_pkg::COUNT_W-1:0]          count
);
    import svft_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic signed [DIFF_W-1:0]  diff;
    logic                      first;

    // Entry against sample; table is sorted so hits form a suffix of the chain
    assign diff            = value_diff(value_reg, sample);
    assign stat.hit        = !valid || above_low(diff, tolerance);
    assign first           = stat.hit && !prev_hit;
    assign stat.near_first = first && valid && below_high(diff, tolerance);

    // Count in place, or open a slot and shift the upper part up by one
    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        if (ctrl.count_en && stat.near_first && (count_reg < limit))
        begin
            count_next = COUNT_W'(count_reg + 1'b1);
        end
        else if (ctrl.insert_en && first)
        begin
            value_next = sample;
            count_next = COUNT_W'(1);
        end
        else if (ctrl.insert_en && prev_hit)
        begin
            value_next = prev_value;
            count_next = prev_count;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        count_reg <= count_next;
    end

    assign value = value_reg;
    assign count = count_reg;

endmodule

// ===== src/sorted_value_frequency_table.sv =====
// Sorted value histogram. Keeps up to TABLE_DEPTH distinct signed Q16.16
// values in ascending order, each with a count that saturates at pixel_total,
// in a row of compare-and-shift cells. cmd ADD counts a sample in the first
// entry within tolerance, inserts it in order, skips it when near nodata_value,
// drops it when the table is full, or reports done once pixel_total samples
// are seen; READ returns entry entry_index; CLEAR empties the table and
// restarts the frame. Every command gives exactly one result beat. All cells
// compare the sample in parallel and shift or count at the accepting edge,
// so an item can be accepted every cycle while the output register is free
// or being drained. No clearing pass is needed after reset. The user must
// write configuration only while the block is idle; it is not enforced.
module sorted_value_frequency_table #(
    parameter int TABLE_DEPTH = svft_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_write,
    input  logic [svft_pkg::CFGI_W-1:0]           cfg_index,
    input  logic [svft_pkg::CFG_W-1:0]            cfg_data,
    // input beat
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [svft_pkg::CMD_W-1:0]            cmd,
    input  logic signed [svft_pkg::VALUE_W-1:0]   sample,
    input  logic [svft_pkg::IDX_W-1:0]            entry_index,
    // result beat
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [svft_pkg::STAT_W-1:0]           status,
    output logic signed [svft_pkg::VALUE_W-1:0]   entry_value,
    output logic [svft_pkg::COUNT_W-1:0]          entry_count,
    output logic [svft_pkg::USED_W-1:0]           entries_used,
    output logic                                  frame_done
);
    import svft_pkg::*;

    localparam int UW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (UW > IDX_W) ? UW : IDX_W;

    // Configuration registers
    logic signed [VALUE_W-1:0] nodata_reg;
    logic [TOL_W-1:0]          tol_reg;
    logic [COUNT_W-1:0]        total_reg;

    // Table control state
    logic [UW-1:0]      used_reg;
    logic [UW-1:0]      used_next;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] seen_next;
    logic               out_valid_reg;

    // Output payload
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VALUE_W-1:0] value_out_reg;
    logic signed [VALUE_W-1:0] value_out_next;
    logic [COUNT_W-1:0]        count_out_reg;
    logic [COUNT_W-1:0]        count_out_next;
    logic [USED_W-1:0]         used_out_reg;
    logic                      done_out_reg;

    logic               accept;
    cmd_t               cmd_in;
    logic [COUNT_W-1:0] limit;
    logic signed [DIFF_W-1:0] nd_diff;
    logic               nodata_near;
    logic               count_hit;
    logic               index_ok;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        read_count;
    cell_ctrl_t         ctrl;

    cell_stat_t                cell_stat  [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] cell_value [TABLE_DEPTH];
    logic [COUNT_W-1:0]        cell_count [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    near_vec;

    // Handshake: output register frees when its beat is taken
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign cmd_in   = cmd_t'(cmd);

    // A pixel total of zero behaves as one
    assign limit = (total_reg == '0) ? COUNT_W'(1) : total_reg;

    assign nd_diff     = value_diff(sample, nodata_reg);
    assign nodata_near = above_low(nd_diff, tol_reg) && below_high(nd_diff, tol_reg);

    // Cell row
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic                      prev_hit;
        logic signed [VALUE_W-1:0] prev_value;
        logic [COUNT_W-1:0]        prev_count;

        if (g == 0)
        begin : g_head
            assign prev_hit   = 1'b0;
            assign prev_value = sample;
            assign prev_count = '0;
        end
        else
        begin : g_link
            assign prev_hit   = cell_stat[g-1].hit;
            assign prev_value = cell_value[g-1];
            assign prev_count = cell_count[g-1];
        end

        svft_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (UW'(g) < used_reg),
            .sample     (sample),
            .tolerance  (tol_reg),
            .limit      (limit),
            .prev_hit   (prev_hit),
            .prev_value (prev_value),
            .prev_count (prev_count),
            .stat       (cell_stat[g]),
            .value      (cell_value[g]),
            .count      (cell_count[g])
        );

        assign near_vec[g] = cell_stat[g].near_first;
    end

    assign count_hit = |near_vec;

    // Read select
    assign index_ok = CMPW'(entry_index) < CMPW'(used_reg);

    always_comb
    begin
        read_value = '0;
        read_count = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (CMPW'(entry_index) == CMPW'(i))
            begin
                read_value = read_value | cell_value[i];
                read_count = read_count | cell_count[i];
            end
        end
    end

    // Command decode
    always_comb
    begin
        ctrl           = '0;
        status_next    = ST_COUNTED;
        used_next      = used_reg;
        seen_next      = seen_reg;
        value_out_next = '0;
        count_out_next = '0;
        if (accept)
        begin
            case (cmd_in)
                CMD_ADD:
                begin
                    if (seen_reg >= limit)
                    begin
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        seen_next = COUNT_W'(seen_reg + 1'b1);
                        if (nodata_near)
                        begin
                            status_next = ST_SKIPPED;
                        end
                        else if (count_hit)
                        begin
                            status_next   = ST_COUNTED;
                            ctrl.count_en = 1'b1;
                        end
                        else if (used_reg >= UW'(TABLE_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next    = ST_INSERTED;
                            ctrl.insert_en = 1'b1;
                            used_next      = UW'(used_reg + 1'b1);
                        end
                    end
                end
                CMD_READ:
                begin
                    if (index_ok)
                    begin
                        value_out_next = read_value;
                        count_out_next = read_count;
                    end
                    else
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                end
                CMD_CLEAR:
                begin
                    used_next = '0;
                    seen_next = '0;
                end
                default:
                begin
                    status_next = ST_COUNTED;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodata_reg <= NODATA_RST;
            tol_reg    <= TOL_RST;
            total_reg  <= TOTAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NODATA:      nodata_reg <= $signed(cfg_data[VALUE_W-1:0]);
                REG_TOLERANCE:   tol_reg    <= cfg_data[TOL_W-1:0];
                REG_PIXEL_TOTAL: total_reg  <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            seen_reg      <= seen_next;
            out_valid_reg <= accept || (out_valid_reg && out_stall);
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
            count_out_reg <= count_out_next;
            used_out_reg  <= USED_W'(used_next);
            done_out_reg  <= (seen_next >= limit);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_value  = value_out_reg;
    assign entry_count  = count_out_reg;
    assign entries_used = used_out_reg;
    assign frame_done   = done_out_reg;

    // Table never grows past its depth
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // An insert grows the table by exactly one entry
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status_next == ST_INSERTED)) |=>
        (used_reg == UW'($past(used_reg) + 1'b1)))
        else $error("insert did not grow the table by one");

    // A done result always reports the frame as done
    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_DONE)) |-> frame_done)
        else $error("done status without frame_done");

endmodule
